[hdl/bwma_pkg.sv]
package bwma_pkg;

  localparam int HIST_DEPTH = 5;   // boxes held
  localparam int FIELD_CNT  = 4;   // x, y, width, height
  localparam int TAP_W      = 3;   // index into history, also fill count
  localparam int WEIGHT_W   = 3;   // per-tap weight, 2..6
  localparam int DIVISOR_W  = 5;   // weight totals, up to 20
  localparam int SUM_EXTRA  = 5;   // growth of weighted sum over a coordinate

  // control from sequencer to every lane
  typedef struct packed {
    logic clear;
    logic acc_en;
    logic div_en;
  } lane_ctrl_t;

  // weight of history entry idx, newest first
  function automatic logic [WEIGHT_W-1:0] tap_weight(input logic [TAP_W-1:0] idx);
    logic [WEIGHT_W-1:0] w;
    unique case (idx)
      3'd0:    w = 3'd6;
      3'd1:    w = 3'd5;
      3'd2:    w = 3'd4;
      3'd3:    w = 3'd3;
      3'd4:    w = 3'd2;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

  // sum of the weights of the newest cnt entries
  function automatic logic [DIVISOR_W-1:0] weight_total(input logic [TAP_W-1:0] cnt);
    logic [DIVISOR_W-1:0] t;
    unique case (cnt)
      3'd1:    t = 5'd6;
      3'd2:    t = 5'd11;
      3'd3:    t = 5'd15;
      3'd4:    t = 5'd18;
      default: t = 5'd20;
    endcase
    return t;
  endfunction

endpackage

[hdl/bwma_lane.sv]
// One coordinate: multiply-accumulate over the taps, then restoring divide.
module bwma_lane import bwma_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  lane_ctrl_t            ctrl,
  input  logic [COORD_BITS-1:0] tap,
  input  logic [WEIGHT_W-1:0]   weight,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [COORD_BITS-1:0] quotient
);

  localparam int SUM_W  = COORD_BITS + SUM_EXTRA;
  localparam int PROD_W = COORD_BITS + WEIGHT_W;

  logic [SUM_W-1:0]     acc;      // weighted sum, becomes the quotient
  logic [DIVISOR_W-1:0] rem;
  logic [PROD_W-1:0]    prod;
  logic [DIVISOR_W:0]   trial;
  logic                 ge;

  always_comb begin
    prod  = PROD_W'(tap) * PROD_W'(weight);
    trial = {rem, acc[SUM_W-1]};
    ge    = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
      rem <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + SUM_W'(prod);
    end else if (ctrl.div_en) begin
      // one quotient bit per cycle, MSB first
      acc <= {acc[SUM_W-2:0], ge};
      rem <= ge ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient = acc[COORD_BITS-1:0];

endmodule

[hdl/bwma_merge.sv]
// Gathers lane quotients into one result word and holds it for the sink.
module bwma_merge import bwma_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int DATA_W     = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic [FIELD_CNT-1:0][COORD_BITS-1:0] quot,
  output logic                                 ready,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [DATA_W-1:0]                    m_tdata
);

  assign ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load && ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ready) begin
      m_tdata <= DATA_W'(quot);   // field 0 lands in the low bits
    end
  end

endmodule

[hdl/box_weighted_moving_average.sv]
// Five-tap weighted moving average of bounding boxes.
// Slave channel s_*: one box per transfer, tdata = {height, width, y, x}
//   packed from bit 0 up, COORD_BITS each, zero padded to whole bytes.
// Master channel m_*: one smoothed box per input, same packing.
// Weights are 6,5,4,3,2 twentieths, newest first; while fewer than five
//   boxes are held, only the held ones count and the sum is divided by
//   their weight total. Quotients truncate.
// Four lanes (one per coordinate) run side by side: multiply-accumulate
//   over the n boxes held (n = 1..5), then bit-serial restoring division,
//   then a final step hands the result to the output register. s_tready
//   rises at the same edge as m_tvalid, and no new input transfer is
//   taken until the current box is through.
// A result waiting on a stalled sink does not block the next input; the
//   block only holds in its final step if the previous result is still
//   unclaimed when the next one is ready.
// Reset (rst, synchronous) empties the history and drops any pending result.
module box_weighted_moving_average import bwma_pkg::*; #(
  parameter  int COORD_BITS = 12,
  localparam int DATA_W     = ((FIELD_CNT * COORD_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // box_x, box_y, box_width, box_height
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata    // smooth_x, smooth_y, smooth_width, smooth_height
);

  localparam int SUM_W  = COORD_BITS + SUM_EXTRA;
  localparam int DCNT_W = $clog2(SUM_W);

  typedef enum logic [1:0] {ST_IDLE, ST_ACC, ST_DIV, ST_DONE} state_t;

  state_t                               state;
  logic [TAP_W-1:0]                     fill;      // boxes held, 0..5
  logic [TAP_W-1:0]                     fill_next;
  logic [TAP_W-1:0]                     tap;       // history entry in work
  logic [DCNT_W-1:0]                    dcnt;      // divide steps left - 1
  logic [DIVISOR_W-1:0]                 divisor;
  logic [FIELD_CNT-1:0][COORD_BITS-1:0] hist [HIST_DEPTH];  // entry 0 newest
  logic [FIELD_CNT-1:0][COORD_BITS-1:0] hist_tap;
  logic [FIELD_CNT-1:0][COORD_BITS-1:0] quot;
  lane_ctrl_t                           ctrl;
  logic                                 in_xfer;
  logic                                 merge_ready;
  logic [WEIGHT_W-1:0]                  weight;

  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign fill_next = (fill < TAP_W'(HIST_DEPTH)) ? fill + 1'b1 : fill;
  assign hist_tap  = hist[tap];
  assign weight    = tap_weight(tap);

  always_comb begin
    ctrl.clear  = in_xfer;
    ctrl.acc_en = (state == ST_ACC);
    ctrl.div_en = (state == ST_DIV);
  end

  // history shift line: payload only, unused entries are never read
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int k = HIST_DEPTH - 1; k > 0; k--) begin
        hist[k] <= hist[k-1];
      end
      hist[0] <= (FIELD_CNT * COORD_BITS)'(s_tdata);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      fill    <= '0;
      tap     <= '0;
      dcnt    <= '0;
      divisor <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            fill    <= fill_next;
            divisor <= weight_total(fill_next);
            tap     <= '0;
            state   <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (tap + 1'b1 == fill) begin
            dcnt  <= DCNT_W'(SUM_W - 1);
            state <= ST_DIV;
          end else begin
            tap <= tap + 1'b1;
          end
        end
        ST_DIV: begin
          if (dcnt == '0) begin
            state <= ST_DONE;
          end else begin
            dcnt <= dcnt - 1'b1;
          end
        end
        ST_DONE: begin
          if (merge_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  for (genvar f = 0; f < FIELD_CNT; f++) begin : g_lane
    bwma_lane #(
      .COORD_BITS(COORD_BITS)
    ) u_lane (
      .clk     (clk),
      .ctrl    (ctrl),
      .tap     (hist_tap[f]),
      .weight  (weight),
      .divisor (divisor),
      .quotient(quot[f])
    );
  end

  bwma_merge #(
    .COORD_BITS(COORD_BITS),
    .DATA_W    (DATA_W)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .load    (state == ST_DONE),
    .quot    (quot),
    .ready   (merge_ready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule

[tb/sv/tb_box_weighted_moving_average.sv]
`timescale 1ns / 100ps

module tb_box_weighted_moving_average;
  import bwma_pkg::*;

  localparam int COORD_BITS  = 12;
  localparam int DATA_W      = ((FIELD_CNT * COORD_BITS + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;   // watchdog bound for the whole run
  localparam int TAIL_CYCLES = 60;       // settle time after the last result
  localparam int RAND_PER_PACE = 110;    // five pacing stretches, ~550 random boxes

  typedef logic [COORD_BITS-1:0] coord_t;

  // Declared height first so x lands in the low bits, matching tdata.
  typedef struct packed {
    coord_t height;
    coord_t width;
    coord_t y;
    coord_t x;
  } box_t;

  // How the two sides of the bus behave while a stretch of boxes is sent.
  typedef enum int {
    PACE_STEADY,       // no idling, no stalls
    PACE_SRC_IDLE,     // sender idles
    PACE_SINK_STALL,   // receiver stalls
    PACE_BOTH          // both at once
  } pace_t;

  localparam int SRC_IDLE_PCT[4]   = '{0, 51, 0, 32};
  localparam int SINK_STALL_PCT[4] = '{0, 0, 51, 32};

  // Tap weights in twentieths, newest box first.
  localparam int unsigned TAP_WT[HIST_DEPTH] = '{6, 5, 4, 3, 2};

  typedef struct {
    box_t  box;
    pace_t pace;
    bit    drain;   // hold off until every smoothed box is back
  } box_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;    // box_x, box_y, box_width, box_height
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;         // smooth_x, smooth_y, smooth_width, smooth_height

  box_item_t pending_boxes[$];   // boxes not yet offered on the slave side
  box_t      smoothed_due[$];    // smoothed boxes still owed by the block

  // Shadow of the block's history, newest at index 0.
  box_t      track_hist[HIST_DEPTH];
  int        track_held = 0;

  logic      in_fire = 1'b0;     // slave transfer at the last rising edge
  pace_t     cur_pace = PACE_STEADY;
  int        mismatches = 0;
  int        cycles = 0;
  box_t      got_box;
  box_t      want_box;

  box_weighted_moving_average #(
    .COORD_BITS (COORD_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Push one box into the tracked history and return its weighted average.
  // While the history is filling only the held taps count, and the divisor
  // is the sum of just those weights.
  function automatic box_t smooth_box(input box_t fresh);
    int unsigned sx;
    int unsigned sy;
    int unsigned sw;
    int unsigned sh;
    int unsigned wsum;
    box_t        avg;
    for (int k = HIST_DEPTH - 1; k > 0; k--) track_hist[k] = track_hist[k - 1];
    track_hist[0] = fresh;
    if (track_held < HIST_DEPTH) track_held++;
    sx = 0; sy = 0; sw = 0; sh = 0; wsum = 0;
    for (int k = 0; k < track_held; k++) begin
      sx   += TAP_WT[k] * track_hist[k].x;
      sy   += TAP_WT[k] * track_hist[k].y;
      sw   += TAP_WT[k] * track_hist[k].width;
      sh   += TAP_WT[k] * track_hist[k].height;
      wsum += TAP_WT[k];
    end
    // Quotients truncate; an average cannot leave the coordinate range.
    avg.x      = coord_t'(sx / wsum);
    avg.y      = coord_t'(sy / wsum);
    avg.width  = coord_t'(sw / wsum);
    avg.height = coord_t'(sh / wsum);
    return avg;
  endfunction

  function automatic box_t make_box(input int x, input int y, input int w, input int h);
    box_t b;
    b.x = coord_t'(x);
    b.y = coord_t'(y);
    b.width = coord_t'(w);
    b.height = coord_t'(h);
    return b;
  endfunction

  // Random boxes: free content in four picks of ten, plus a tracked box that
  // drifts a little each frame, corner values, and repeats of the previous box.
  function automatic box_t random_box(input box_t prev);
    int   pick;
    box_t b;
    pick = $urandom_range(9);
    case (pick)
      0, 1, 2, 3: begin
        b = make_box($urandom_range(4095), $urandom_range(4095),
                     $urandom_range(4095), $urandom_range(4095));
      end
      4, 5: begin
        b.x      = prev.x + coord_t'($urandom_range(32)) - coord_t'(16);
        b.y      = prev.y + coord_t'($urandom_range(32)) - coord_t'(16);
        b.width  = prev.width + coord_t'($urandom_range(16)) - coord_t'(8);
        b.height = prev.height + coord_t'($urandom_range(16)) - coord_t'(8);
      end
      6: begin
        b = make_box($urandom_range(1) * 4095, $urandom_range(1) * 4095,
                     $urandom_range(1) * 4095, $urandom_range(1) * 4095);
      end
      7: begin
        b = make_box($urandom_range(15), $urandom_range(15),
                     $urandom_range(15), $urandom_range(15));
      end
      8: begin
        b = make_box($urandom_range(4095, 4080), $urandom_range(4095, 4080),
                     $urandom_range(4095, 4080), $urandom_range(4095, 4080));
      end
      default: begin
        b = prev;
      end
    endcase
    return b;
  endfunction

  task automatic queue_box(input box_t b, input pace_t p, input bit drain);
    box_item_t item;
    item.box = b;
    item.pace = p;
    item.drain = drain;
    pending_boxes.insert(pending_boxes.size(), item);
  endtask

  // Stimulus, reset and the end of the run.
  initial begin
    box_t  prev;
    pace_t pace_plan[5];
    pace_plan = '{PACE_STEADY, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH, PACE_STEADY};

    // Right after reset the history fills one box at a time, so the first
    // five boxes hit every partial divisor (6, 11, 15, 18, then 20).
    queue_box(make_box(4095,    1, 4095,    0), PACE_STEADY, 1'b0);
    queue_box(make_box(   0, 4095, 4095,    0), PACE_STEADY, 1'b0);
    queue_box(make_box(4095,    2, 4095,    0), PACE_STEADY, 1'b0);
    queue_box(make_box(   0, 4094, 4095,    0), PACE_STEADY, 1'b0);
    queue_box(make_box(4095,    3, 4095, 4095), PACE_STEADY, 1'b0);
    // Full history: oldest drops out with each new box.
    queue_box(make_box(   0,    0,    0,    0), PACE_STEADY, 1'b0);
    queue_box(make_box(4095,    0, 4095,    0), PACE_STEADY, 1'b0);
    queue_box(make_box(   0, 4095,    0, 4095), PACE_STEADY, 1'b0);
    queue_box(make_box('hAAA, 'h555, 'hAAA, 'h555), PACE_STEADY, 1'b0);
    queue_box(make_box('h555, 'hAAA, 'h555, 'hAAA), PACE_STEADY, 1'b0);
    queue_box(make_box(   1, 2048,    1, 2048), PACE_STEADY, 1'b0);
    // Flush to zero, then a lone max box shows each tap weight alone.
    for (int i = 0; i < 5; i++) queue_box(make_box(0, 0, 0, 0), PACE_STEADY, 1'b0);
    queue_box(make_box(4095, 4095, 4095, 4095), PACE_STEADY, 1'b0);
    for (int i = 0; i < 4; i++) queue_box(make_box(0, 0, 0, 0), PACE_STEADY, 1'b0);
    // All max: the widest weighted sum.
    for (int i = 0; i < 5; i++) queue_box(make_box(4095, 4095, 4095, 4095), PACE_STEADY, 1'b0);

    prev = make_box(4095, 4095, 4095, 4095);
    foreach (pace_plan[p]) begin
      for (int i = 0; i < RAND_PER_PACE; i++) begin
        prev = random_box(prev);
        // First box of each stretch waits for the block to drain.
        queue_box(prev, pace_plan[p], i == 0);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    wait (pending_boxes.size() == 0 && !s_tvalid && smoothed_due.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_box_weighted_moving_average: PASS");
    end else begin
      $display("tb_box_weighted_moving_average: FAIL");
    end
    $finish;
  end

  // Driver: all inputs change on the falling edge. A new box is offered only
  // once the previous one has been taken in a transfer, so s_tvalid never
  // drops while a box waits.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      m_tready <= 1'b0;
    end else begin
      if (pending_boxes.size() > 0) cur_pace = pending_boxes[0].pace;
      m_tready <= ($urandom_range(99) >= SINK_STALL_PCT[cur_pace]);
      if (!s_tvalid || in_fire) begin
        if (pending_boxes.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if ((pending_boxes[0].drain && smoothed_due.size() > 0) ||
                     $urandom_range(99) < SRC_IDLE_PCT[cur_pace]) begin
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata  <= DATA_W'(pending_boxes[0].box);
          pending_boxes.delete(0);
        end
      end
    end
  end

  // Monitor: both channels sampled at the rising edge. Each slave transfer
  // adds one smoothed box to the due list; each master transfer must match
  // the oldest one.
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got_box = box_t'(m_tdata);
        if (smoothed_due.size() == 0) begin
          $error("unexpected result transfer, m_tdata = %h", m_tdata);
          mismatches++;
        end else begin
          want_box = smoothed_due[0];
          smoothed_due.delete(0);
          if (got_box.x !== want_box.x) begin
            $error("smooth_x: expected %0d, got %0d", want_box.x, got_box.x);
            mismatches++;
          end
          if (got_box.y !== want_box.y) begin
            $error("smooth_y: expected %0d, got %0d", want_box.y, got_box.y);
            mismatches++;
          end
          if (got_box.width !== want_box.width) begin
            $error("smooth_width: expected %0d, got %0d", want_box.width, got_box.width);
            mismatches++;
          end
          if (got_box.height !== want_box.height) begin
            $error("smooth_height: expected %0d, got %0d", want_box.height, got_box.height);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        smoothed_due.insert(smoothed_due.size(), smooth_box(box_t'(s_tdata)));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_box_weighted_moving_average: FAIL");
      $finish;
    end
  end

endmodule
